// ===== rtl/nbg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nbg_pkg
// shared constants, types and saturation helper for the gravity step block
// ----------------------------------------------------------------------------
package nbg_pkg;

    localparam int MAX_BODIES = 64;
    localparam int FRAC_BITS  = 16;
    localparam int RESULT_CAP = 64;

    localparam int IDX_W  = (MAX_BODIES > 2) ? $clog2(MAX_BODIES) : 1;
    localparam int CNT_W  = $clog2(MAX_BODIES + 1);
    localparam int BIDX_W = 6;

    // divider: dividend up to a 64-bit value shifted by the fraction bits
    localparam int DIV_W  = 64 + FRAC_BITS;
    localparam int DIV_CW = $clog2(DIV_W);
    localparam int DVS_W  = 33;

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_SKIP = 2'd2;
    localparam logic [1:0] ST_SAT  = 2'd3;

    typedef struct packed {
        logic        [31:0] mass;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_x;
    } body_t;

    localparam int BODY_W = $bits(body_t);

    typedef struct packed {
        logic [31:0] val;
        logic        hit;
    } sat_t;

    localparam logic signed [35:0] S32_MAX = 36'sh07FFFFFFF;
    localparam logic signed [35:0] S32_MIN = 36'shF80000000;

    // clamp to the signed 32-bit range
    function automatic sat_t sat32(input logic signed [35:0] v);
        sat_t r;
        if (v > S32_MAX)
        begin
            r.val = 32'h7FFFFFFF;
            r.hit = 1'b1;
        end
        else if (v < S32_MIN)
        begin
            r.val = 32'h80000000;
            r.hit = 1'b1;
        end
        else
        begin
            r.val = v[31:0];
            r.hit = 1'b0;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/nbg_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nbg_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module nbg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ===== rtl/nbg_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nbg_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module nbg_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [nbg_pkg::DIV_W-1:0] dividend,
    input  wire logic [nbg_pkg::DVS_W-1:0] divisor,
    output logic                           done,
    output logic      [nbg_pkg::DIV_W-1:0] quotient
);
    import nbg_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]  dvd_reg, dvd_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DVS_W:0]    shifted;
    logic [DVS_W:0]    diff;
    logic              ge;

    always_comb
    begin
        shifted   = {rem_reg, dvd_reg[DIV_W-1]};
        ge        = (shifted >= {1'b0, dvs_reg});
        diff      = shifted - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CW'(DIV_W - 1);
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
            dvd_next = {dvd_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule
`default_nettype wire

// ===== rtl/nbg_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nbg_sqrt
// digit-by-digit integer square root of a 64-bit value, two bits per cycle
// ----------------------------------------------------------------------------
module nbg_sqrt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] radicand,
    output logic             done,
    output logic      [31:0] root
);
    import nbg_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [63:0] rad_reg, rad_next;
    logic [33:0] rem_reg, rem_next;
    logic [31:0] root_reg, root_next;
    logic [35:0] shifted;
    logic [35:0] trial;
    logic [35:0] diff;

    always_comb
    begin
        shifted   = {rem_reg, rad_reg[63:62]};
        trial     = {2'b00, root_reg, 2'b01};
        diff      = shifted - trial;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd31;
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[61:0], 2'b00};
            cnt_next = cnt_reg - 1'b1;
            if (shifted >= trial)
            begin
                rem_next  = diff[33:0];
                root_next = {root_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[33:0];
                root_next = {root_reg[30:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule
`default_nettype wire

// ===== rtl/nbody_gravity_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// an add transfer gives its result in the cycle after it is taken
// per ordered body pair a step runs four divisions on the shared divider (one bit
// per cycle) and one square root on the square-root unit; result stalls can hold a step
// one item at a time: s_axis_tready is low while a step runs
// reset: body count zero, gravity constant 1.0, body table contents unknown
// ----------------------------------------------------------------------------
// nbody_gravity_step
// direct-sum gravity on a table of bodies with in-place explicit euler update
// ----------------------------------------------------------------------------
module nbody_gravity_step (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // config: gravity constant, unsigned q16.16
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [31:0]  cfg_data,
    // input stream
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [159:0] s_axis_tdata,  // pos_x, pos_y, vel_x, vel_y, mass
    input  wire logic         s_axis_tuser,  // kind
    // result stream
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic      [135:0] m_axis_tdata,  // body_index, out_x, out_y, out_vx, out_vy, pad
    output logic      [1:0]   m_axis_tuser,  // status
    output logic              m_axis_tlast
);
    import nbg_pkg::*;

    typedef enum logic [26:0] {
        S_IDLE = 27'd1 << 0,
        S_RD_I = 27'd1 << 1,
        S_LD_I = 27'd1 << 2,
        S_RD_J = 27'd1 << 3,
        S_LD_J = 27'd1 << 4,
        S_CHK  = 27'd1 << 5,
        S_SQA  = 27'd1 << 6,
        S_SQB  = 27'd1 << 7,
        S_SUM  = 27'd1 << 8,
        S_SQS  = 27'd1 << 9,
        S_SQW  = 27'd1 << 10,
        S_MG   = 27'd1 << 11,
        S_DQS  = 27'd1 << 12,
        S_DQW  = 27'd1 << 13,
        S_DAS  = 27'd1 << 14,
        S_DAW  = 27'd1 << 15,
        S_MXM  = 27'd1 << 16,
        S_DXS  = 27'd1 << 17,
        S_DXW  = 27'd1 << 18,
        S_MYM  = 27'd1 << 19,
        S_DYS  = 27'd1 << 20,
        S_DYW  = 27'd1 << 21,
        S_UPV  = 27'd1 << 22,
        S_UPP  = 27'd1 << 23,
        S_NXJ  = 27'd1 << 24,
        S_WB   = 27'd1 << 25,
        S_EMIT = 27'd1 << 26
    } state_t;

    // control
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [31:0]       gconst_reg, gconst_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic              ov_reg, ov_next;

    // body i working copy
    logic signed [31:0] xi_reg, xi_next;
    logic signed [31:0] yi_reg, yi_next;
    logic signed [31:0] vxi_reg, vxi_next;
    logic signed [31:0] vyi_reg, vyi_next;
    logic [31:0]        mi_reg, mi_next;
    logic               sat_reg, sat_next;
    logic               skip_reg, skip_next;

    // pair datapath
    logic [31:0]        mj_reg, mj_next;
    logic signed [32:0] dx_reg, dx_next;
    logic signed [32:0] dy_reg, dy_next;
    logic [32:0]        adx_reg, adx_next;
    logic [32:0]        ady_reg, ady_next;
    logic [31:0]        a_reg, a_next;
    logic [31:0]        b_reg, b_next;
    logic               big_reg, big_next;
    logic [65:0]        prod_reg, prod_next;
    logic [63:0]        sum_reg, sum_next;
    logic [32:0]        d_reg, d_next;
    logic [31:0]        acc_reg, acc_next;
    logic [33:0]        mx_reg, mx_next;
    logic [33:0]        my_reg, my_next;

    // result register
    logic [BIDX_W-1:0]  oidx_reg, oidx_next;
    logic [31:0]        ox_reg, ox_next;
    logic [31:0]        oy_reg, oy_next;
    logic [31:0]        ovx_reg, ovx_next;
    logic [31:0]        ovy_reg, ovy_next;
    logic [1:0]         ost_reg, ost_next;
    logic               olast_reg, olast_next;

    // shared units
    logic [32:0]        mul_a, mul_b;
    logic [65:0]        mul_p;
    logic               sq_start, sq_done;
    logic [31:0]        sq_root;
    logic               dv_start, dv_done;
    logic [DIV_W-1:0]   dv_dividend, dv_quot;

    // body table
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr, ram_raddr;
    body_t              ram_wdata, ram_rdata, in_body;

    logic               in_xfer, out_xfer;
    logic [31:0]        i_ext, j_ext, n_ext, shown;
    logic [32:0]        adx_c, ady_c;
    logic signed [35:0] ax, ay;
    sat_t               s0, s1;

    assign in_body   = body_t'(s_axis_tdata);
    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign out_xfer  = ov_reg && m_axis_tready;
    assign cfg_ready = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE) && !ov_reg;

    // shared multiplier, one product per cycle, registered in prod_reg
    assign mul_p = mul_a * mul_b;

    nbg_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sum_reg),
        .done     (sq_done),
        .root     (sq_root)
    );

    nbg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dv_start),
        .dividend (dv_dividend),
        .divisor  (d_reg),
        .done     (dv_done),
        .quotient (dv_quot)
    );

    nbg_ram #(
        .WIDTH (BODY_W),
        .DEPTH (MAX_BODIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_comb
    begin
        i_ext = 32'(i_reg);
        j_ext = 32'(j_reg);
        n_ext = 32'(count_reg);
        shown = (n_ext < 32'(RESULT_CAP)) ? n_ext : 32'(RESULT_CAP);
        adx_c = dx_reg[32] ? 33'(-dx_reg) : 33'(dx_reg);
        ady_c = dy_reg[32] ? 33'(-dy_reg) : 33'(dy_reg);
        ax    = dx_reg[32] ? -$signed({2'b00, mx_reg}) : $signed({2'b00, mx_reg});
        ay    = dy_reg[32] ? -$signed({2'b00, my_reg}) : $signed({2'b00, my_reg});
        s0    = '0;
        s1    = '0;

        state_next  = state_reg;
        count_next  = count_reg;
        gconst_next = gconst_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        ov_next     = out_xfer ? 1'b0 : ov_reg;
        xi_next     = xi_reg;
        yi_next     = yi_reg;
        vxi_next    = vxi_reg;
        vyi_next    = vyi_reg;
        mi_next     = mi_reg;
        sat_next    = sat_reg;
        skip_next   = skip_reg;
        mj_next     = mj_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        adx_next    = adx_reg;
        ady_next    = ady_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        big_next    = big_reg;
        prod_next   = prod_reg;
        sum_next    = sum_reg;
        d_next      = d_reg;
        acc_next    = acc_reg;
        mx_next     = mx_reg;
        my_next     = my_reg;
        oidx_next   = oidx_reg;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        ovx_next    = ovx_reg;
        ovy_next    = ovy_reg;
        ost_next    = ost_reg;
        olast_next  = olast_reg;

        mul_a       = '0;
        mul_b       = '0;
        sq_start    = 1'b0;
        dv_start    = 1'b0;
        dv_dividend = DIV_W'(prod_reg);
        ram_we      = 1'b0;
        ram_waddr   = i_reg;
        ram_wdata   = {mi_reg, vyi_reg, vxi_reg, yi_reg, xi_reg};
        ram_raddr   = j_reg;

        if (cfg_valid)
        begin
            gconst_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (s_axis_tuser == KIND_ADD)
                    begin
                        ov_next    = 1'b1;
                        olast_next = 1'b1;
                        if (count_reg == CNT_W'(MAX_BODIES))
                        begin
                            // table full: nothing stored, zero payload
                            oidx_next = '0;
                            ox_next   = '0;
                            oy_next   = '0;
                            ovx_next  = '0;
                            ovy_next  = '0;
                            ost_next  = ST_FULL;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = count_reg[IDX_W-1:0];
                            ram_wdata  = in_body;
                            count_next = count_reg + 1'b1;
                            oidx_next  = n_ext[BIDX_W-1:0];
                            ox_next    = in_body.pos_x;
                            oy_next    = in_body.pos_y;
                            ovx_next   = in_body.vel_x;
                            ovy_next   = in_body.vel_y;
                            ost_next   = ST_OK;
                        end
                    end
                    else if (count_reg != '0)
                    begin
                        i_next     = '0;
                        state_next = S_RD_I;
                    end
                end
            end
            S_RD_I:
            begin
                ram_raddr  = i_reg;
                state_next = S_LD_I;
            end
            S_LD_I:
            begin
                xi_next    = ram_rdata.pos_x;
                yi_next    = ram_rdata.pos_y;
                vxi_next   = ram_rdata.vel_x;
                vyi_next   = ram_rdata.vel_y;
                mi_next    = ram_rdata.mass;
                sat_next   = 1'b0;
                skip_next  = 1'b0;
                j_next     = '0;
                state_next = S_RD_J;
            end
            S_RD_J:
            begin
                // a body does not pull on itself
                state_next = (j_reg == i_reg) ? S_NXJ : S_LD_J;
            end
            S_LD_J:
            begin
                dx_next    = {ram_rdata.pos_x[31], ram_rdata.pos_x} - {xi_reg[31], xi_reg};
                dy_next    = {ram_rdata.pos_y[31], ram_rdata.pos_y} - {yi_reg[31], yi_reg};
                mj_next    = ram_rdata.mass;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (dx_reg == '0 && dy_reg == '0)
                begin
                    // coincident pair
                    skip_next  = 1'b1;
                    state_next = S_NXJ;
                end
                else
                begin
                    adx_next   = adx_c;
                    ady_next   = ady_c;
                    // far apart: halve both so the squares fit
                    big_next   = adx_c[32] | adx_c[31] | ady_c[32] | ady_c[31];
                    if (adx_c[32] | adx_c[31] | ady_c[32] | ady_c[31])
                    begin
                        a_next = adx_c[32:1];
                        b_next = ady_c[32:1];
                    end
                    else
                    begin
                        a_next = adx_c[31:0];
                        b_next = ady_c[31:0];
                    end
                    state_next = S_SQA;
                end
            end
            S_SQA:
            begin
                mul_a      = {1'b0, a_reg};
                mul_b      = {1'b0, a_reg};
                prod_next  = mul_p;
                state_next = S_SQB;
            end
            S_SQB:
            begin
                mul_a      = {1'b0, b_reg};
                mul_b      = {1'b0, b_reg};
                sum_next   = prod_reg[63:0];
                prod_next  = mul_p;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                sum_next   = sum_reg + prod_reg[63:0];
                state_next = S_SQS;
            end
            S_SQS:
            begin
                sq_start   = 1'b1;
                state_next = S_SQW;
            end
            S_SQW:
            begin
                if (sq_done)
                begin
                    d_next     = big_reg ? {sq_root, 1'b0} : {1'b0, sq_root};
                    state_next = S_MG;
                end
            end
            S_MG:
            begin
                if (d_reg == '0)
                begin
                    skip_next  = 1'b1;
                    state_next = S_NXJ;
                end
                else
                begin
                    mul_a      = {1'b0, gconst_reg};
                    mul_b      = {1'b0, mj_reg};
                    prod_next  = mul_p;
                    state_next = S_DQS;
                end
            end
            S_DQS:
            begin
                // q = g * m / d
                dv_start    = 1'b1;
                dv_dividend = DIV_W'(prod_reg[63:0]);
                state_next  = S_DQW;
            end
            S_DQW:
            begin
                if (dv_done)
                begin
                    sum_next   = dv_quot[63:0];
                    state_next = S_DAS;
                end
            end
            S_DAS:
            begin
                // acc = q * 2^frac / d
                dv_start    = 1'b1;
                dv_dividend = {sum_reg, {FRAC_BITS{1'b0}}};
                state_next  = S_DAW;
            end
            S_DAW:
            begin
                if (dv_done)
                begin
                    if (|dv_quot[DIV_W-1:32])
                    begin
                        acc_next = 32'hFFFFFFFF;
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = dv_quot[31:0];
                    end
                    state_next = S_MXM;
                end
            end
            S_MXM:
            begin
                mul_a      = {1'b0, acc_reg};
                mul_b      = adx_reg;
                prod_next  = mul_p;
                state_next = S_DXS;
            end
            S_DXS:
            begin
                dv_start   = 1'b1;
                state_next = S_DXW;
            end
            S_DXW:
            begin
                if (dv_done)
                begin
                    mx_next    = dv_quot[33:0];
                    state_next = S_MYM;
                end
            end
            S_MYM:
            begin
                mul_a      = {1'b0, acc_reg};
                mul_b      = ady_reg;
                prod_next  = mul_p;
                state_next = S_DYS;
            end
            S_DYS:
            begin
                dv_start   = 1'b1;
                state_next = S_DYW;
            end
            S_DYW:
            begin
                if (dv_done)
                begin
                    my_next    = dv_quot[33:0];
                    state_next = S_UPV;
                end
            end
            S_UPV:
            begin
                s0         = sat32({{4{vxi_reg[31]}}, vxi_reg} + ax);
                s1         = sat32({{4{vyi_reg[31]}}, vyi_reg} + ay);
                vxi_next   = s0.val;
                vyi_next   = s1.val;
                sat_next   = sat_reg | s0.hit | s1.hit;
                state_next = S_UPP;
            end
            S_UPP:
            begin
                s0 = sat32(36'({{4{xi_reg[31]}}, xi_reg}) + 36'({{4{vxi_reg[31]}}, vxi_reg}));
                s1 = sat32(36'({{4{yi_reg[31]}}, yi_reg}) + 36'({{4{vyi_reg[31]}}, vyi_reg}));
                xi_next    = s0.val;
                yi_next    = s1.val;
                sat_next   = sat_reg | s0.hit | s1.hit;
                state_next = S_NXJ;
            end
            S_NXJ:
            begin
                if (j_ext + 32'd1 == n_ext)
                begin
                    state_next = S_WB;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_RD_J;
                end
            end
            S_WB:
            begin
                ram_we     = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (i_ext >= 32'(RESULT_CAP) || !ov_reg || m_axis_tready)
                begin
                    if (i_ext < 32'(RESULT_CAP))
                    begin
                        ov_next    = 1'b1;
                        oidx_next  = i_ext[BIDX_W-1:0];
                        ox_next    = xi_reg;
                        oy_next    = yi_reg;
                        ovx_next   = vxi_reg;
                        ovy_next   = vyi_reg;
                        ost_next   = sat_reg ? ST_SAT : (skip_reg ? ST_SKIP : ST_OK);
                        olast_next = (i_ext + 32'd1 == shown);
                    end
                    if (i_ext + 32'd1 == n_ext)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_RD_I;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            gconst_reg <= 32'(1) << FRAC_BITS;
            i_reg      <= '0;
            j_reg      <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            gconst_reg <= gconst_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xi_reg    <= xi_next;
        yi_reg    <= yi_next;
        vxi_reg   <= vxi_next;
        vyi_reg   <= vyi_next;
        mi_reg    <= mi_next;
        sat_reg   <= sat_next;
        skip_reg  <= skip_next;
        mj_reg    <= mj_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        adx_reg   <= adx_next;
        ady_reg   <= ady_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        big_reg   <= big_next;
        prod_reg  <= prod_next;
        sum_reg   <= sum_next;
        d_reg     <= d_next;
        acc_reg   <= acc_next;
        mx_reg    <= mx_next;
        my_reg    <= my_next;
        oidx_reg  <= oidx_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        ovx_reg   <= ovx_next;
        ovy_reg   <= ovy_next;
        ost_reg   <= ost_next;
        olast_reg <= olast_next;
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {2'b00, ovy_reg, ovx_reg, oy_reg, ox_reg, oidx_reg};
    assign m_axis_tuser  = ost_reg;
    assign m_axis_tlast  = olast_reg;

    // no input transfer while a step is running
    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_axis_tready)
        else $error("input taken while a step runs");

    // the table never holds more than its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_BODIES))
        else $error("body count beyond table depth");

    // a step on a nonempty table starts by fetching body zero
    a_step_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && s_axis_tuser == KIND_STEP && count_reg != '0)
        |=> (state_reg == S_RD_I && i_reg == '0))
        else $error("step did not start at body zero");

endmodule
`default_nettype wire
